// ===== src/pgpsbf_pkg.sv =====
// shared types and constants for the signature body framer
package pgpsbf_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_MARKER,
        PH_TYPE,
        PH_CREATED,
        PH_SIGNER,
        PH_PKALG,
        PH_HASHALG,
        PH_QUICK,
        PH_MATERIAL,
        PH_AREALEN,
        PH_SUBLEN,
        PH_SUBLEN_MORE,
        PH_SUBTYPE,
        PH_SUBDATA,
        PH_ERROR
    } phase_t;

    localparam logic [3:0] ROLE_MARKER   = 4'd0;
    localparam logic [3:0] ROLE_TYPE     = 4'd1;
    localparam logic [3:0] ROLE_CREATED  = 4'd2;
    localparam logic [3:0] ROLE_SIGNER   = 4'd3;
    localparam logic [3:0] ROLE_PKALG    = 4'd4;
    localparam logic [3:0] ROLE_HASHALG  = 4'd5;
    localparam logic [3:0] ROLE_AREALEN  = 4'd6;
    localparam logic [3:0] ROLE_SUBLEN   = 4'd7;
    localparam logic [3:0] ROLE_SUBTYPE  = 4'd8;
    localparam logic [3:0] ROLE_SUBDATA  = 4'd9;
    localparam logic [3:0] ROLE_QUICK    = 4'd10;
    localparam logic [3:0] ROLE_MATERIAL = 4'd11;
    localparam logic [3:0] ROLE_ERROR    = 4'd12;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_VERSION = 3'd1;
    localparam logic [2:0] ERR_MARKER  = 3'd2;
    localparam logic [2:0] ERR_OVERRUN = 3'd3;
    localparam logic [2:0] ERR_ZERO    = 3'd4;

    localparam logic [1:0] VER_NONE = 2'd0;
    localparam logic [1:0] VER_OLD  = 2'd1;
    localparam logic [1:0] VER_NEW  = 2'd2;

    localparam logic [7:0] VERSION_2 = 8'd2;
    localparam logic [7:0] VERSION_3 = 8'd3;
    localparam logic [7:0] VERSION_4 = 8'd4;

    localparam logic [7:0]  MARKER_BYTE      = 8'h05;
    localparam logic [7:0]  ONE_OCTET_MAX    = 8'hbf;
    localparam logic [7:0]  TWO_OCTET_MAX    = 8'hfe;
    localparam logic [7:0]  TWO_OCTET_BASE   = 8'hc0;
    localparam logic [31:0] TWO_OCTET_OFFSET = 32'd192;

    localparam logic [2:0] CNT_CREATED_LAST = 3'd3;
    localparam logic [2:0] CNT_SIGNER_LAST  = 3'd7;
    localparam logic [2:0] CNT_FIVE_OCTET   = 3'd4;
    localparam logic [2:0] CNT_TWO_PENDING  = 3'd5;

    localparam int TDATA_IN_W  = 8;
    localparam int TUSER_IN_W  = 9;
    localparam int TDATA_OUT_W = 56;
    localparam int TUSER_OUT_W = 4;

    // output tdata layout, lowest field at the bottom
    typedef struct packed {
        logic [2:0]  pad;
        logic [2:0]  error_code;
        logic        header_done;
        logic [31:0] subpacket_data_length;
        logic        critical_flag;
        logic [6:0]  subpkt_type;
        logic        in_hashed_area;
        logic [7:0]  byte_out;
    } result_t;

endpackage

// ===== src/pgp_signature_body_framer_core.sv =====
// signature body framer: tags each body byte with its role in the packet
//
//  channel   dir  tdata                        tuser                    tlast
//  s_axis    in   data_byte                    start_of_body, version   -
//  m_axis    out  byte, hashed, type, crit,    byte_role                last_of_subpacket
//                 length, header_done, error
//
// one byte per cycle sustained while the result is not stalled
// an input register feeds the parse logic, which writes the result register
// a stalled result holds both registers; the input side keeps accepting into
// the input register while it is free
// rst_n clears the parse state and both valid flags
module pgp_signature_body_framer_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [pgpsbf_pkg::TDATA_IN_W-1:0]     s_tdata,   // data_byte
    input  logic [pgpsbf_pkg::TUSER_IN_W-1:0]     s_tuser,   // start_of_body, body_version
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // byte_out, in_hashed_area, subpkt_type, critical_flag,
    // subpacket_data_length, header_done, error_code, zero pad
    output logic [pgpsbf_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic [pgpsbf_pkg::TUSER_OUT_W-1:0]    m_tuser,   // byte_role
    output logic                                  m_tlast    // last_of_subpacket
);
    import pgpsbf_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic [7:0] in_ver_reg;

    // result register
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg;
    logic [3:0] out_role_reg;
    logic       out_last_reg;

    // parse state
    phase_t      phase_reg, phase_next;
    logic [2:0]  fbc_reg, fbc_next;
    logic [1:0]  ver_reg, ver_next;
    logic [15:0] area_reg, area_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] subrem_reg, subrem_next;
    logic [6:0]  type_reg, type_next;
    logic        crit_reg, crit_next;
    logic        hashed_reg, hashed_next;
    logic [2:0]  err_reg, err_next;

    // state after an optional start
    phase_t      ph_c;
    logic [2:0]  fbc_c;
    logic [1:0]  ver_c;
    logic [15:0] area_c;
    logic [31:0] acc_c;
    logic [31:0] subrem_c;
    logic [6:0]  type_c;
    logic        crit_c;
    logic        hashed_c;
    logic [2:0]  err_c;

    logic        advance;
    logic        raise;
    logic [2:0]  raise_code;
    logic        len_check;
    logic        len_pending;
    logic [31:0] len_total;
    logic        sp_done;
    logic        ar_done;
    logic [15:0] area_dec;
    logic [31:0] acc_shift;
    logic [2:0]  fbc_dec;

    result_t     res;
    logic [3:0]  res_role;
    logic        res_last;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    // start of body restarts the parse
    always_comb
    begin
        ph_c     = phase_reg;
        fbc_c    = fbc_reg;
        ver_c    = ver_reg;
        area_c   = area_reg;
        acc_c    = acc_reg;
        subrem_c = subrem_reg;
        type_c   = type_reg;
        crit_c   = crit_reg;
        hashed_c = hashed_reg;
        err_c    = err_reg;
        if (in_start_reg)
        begin
            fbc_c    = '0;
            area_c   = '0;
            acc_c    = '0;
            subrem_c = '0;
            type_c   = '0;
            crit_c   = 1'b0;
            hashed_c = 1'b0;
            err_c    = ERR_NONE;
            if (in_ver_reg == VERSION_2 || in_ver_reg == VERSION_3)
            begin
                ver_c = VER_OLD;
                ph_c  = PH_MARKER;
            end
            else if (in_ver_reg == VERSION_4)
            begin
                ver_c = VER_NEW;
                ph_c  = PH_TYPE;
            end
            else
            begin
                ver_c = VER_NONE;
                err_c = ERR_VERSION;
                ph_c  = PH_ERROR;
            end
        end
    end

    assign area_dec  = area_c - {15'd0, (area_c != '0)};
    assign acc_shift = {acc_c[23:0], in_byte_reg};
    assign fbc_dec   = fbc_c - {2'd0, (fbc_c != '0)};

    // next state
    always_comb
    begin
        phase_next  = ph_c;
        fbc_next    = fbc_c;
        ver_next    = ver_c;
        area_next   = area_c;
        acc_next    = acc_c;
        subrem_next = subrem_c;
        type_next   = type_c;
        crit_next   = crit_c;
        hashed_next = hashed_c;
        err_next    = err_c;
        raise       = 1'b0;
        raise_code  = ERR_NONE;
        len_check   = 1'b0;
        len_pending = 1'b0;
        len_total   = '0;
        sp_done     = 1'b0;
        ar_done     = 1'b0;

        unique case (ph_c)
            PH_MARKER:
            begin
                if (in_byte_reg != MARKER_BYTE)
                begin
                    raise      = 1'b1;
                    raise_code = ERR_MARKER;
                end
                else
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                fbc_next   = '0;
                phase_next = (ver_c == VER_OLD) ? PH_CREATED : PH_PKALG;
            end
            PH_CREATED:
            begin
                if (fbc_c >= CNT_CREATED_LAST)
                begin
                    fbc_next   = '0;
                    phase_next = PH_SIGNER;
                end
                else
                begin
                    fbc_next = fbc_c + 3'd1;
                end
            end
            PH_SIGNER:
            begin
                if (fbc_c >= CNT_SIGNER_LAST)
                begin
                    fbc_next   = '0;
                    phase_next = PH_PKALG;
                end
                else
                begin
                    fbc_next = fbc_c + 3'd1;
                end
            end
            PH_PKALG:
            begin
                phase_next = PH_HASHALG;
            end
            PH_HASHALG:
            begin
                fbc_next = '0;
                if (ver_c == VER_OLD)
                begin
                    phase_next = PH_QUICK;
                end
                else
                begin
                    hashed_next = 1'b1;
                    area_next   = '0;
                    phase_next  = PH_AREALEN;
                end
            end
            PH_QUICK:
            begin
                if (fbc_c != '0)
                begin
                    fbc_next   = '0;
                    phase_next = PH_MATERIAL;
                end
                else
                begin
                    fbc_next = 3'd1;
                end
            end
            PH_AREALEN:
            begin
                area_next = {area_c[7:0], in_byte_reg};
                if (fbc_c != '0)
                begin
                    fbc_next = '0;
                    if (area_next == '0)
                    begin
                        ar_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SUBLEN;
                    end
                end
                else
                begin
                    fbc_next = 3'd1;
                end
            end
            PH_SUBLEN:
            begin
                area_next = area_dec;
                if (in_byte_reg <= ONE_OCTET_MAX)
                begin
                    len_check = 1'b1;
                    len_total = {24'd0, in_byte_reg};
                end
                else if (in_byte_reg <= TWO_OCTET_MAX)
                begin
                    acc_next    = {24'd0, in_byte_reg - TWO_OCTET_BASE};
                    fbc_next    = CNT_TWO_PENDING;
                    phase_next  = PH_SUBLEN_MORE;
                    len_pending = 1'b1;
                end
                else
                begin
                    acc_next    = '0;
                    fbc_next    = CNT_FIVE_OCTET;
                    phase_next  = PH_SUBLEN_MORE;
                    len_pending = 1'b1;
                end
            end
            PH_SUBLEN_MORE:
            begin
                area_next = area_dec;
                if (fbc_c == CNT_TWO_PENDING)
                begin
                    fbc_next  = '0;
                    len_check = 1'b1;
                    len_total = {acc_c[23:0], 8'd0} + {24'd0, in_byte_reg}
                                + TWO_OCTET_OFFSET;
                end
                else
                begin
                    acc_next = acc_shift;
                    fbc_next = fbc_dec;
                    if (fbc_dec == '0)
                    begin
                        len_check = 1'b1;
                        len_total = acc_shift;
                    end
                    else
                    begin
                        len_pending = 1'b1;
                    end
                end
            end
            PH_SUBTYPE:
            begin
                area_next = area_dec;
                crit_next = in_byte_reg[7];
                type_next = in_byte_reg[6:0];
                if (subrem_c == '0)
                begin
                    sp_done = 1'b1;
                end
                else
                begin
                    phase_next = PH_SUBDATA;
                end
            end
            PH_SUBDATA:
            begin
                area_next   = area_dec;
                subrem_next = subrem_c - {31'd0, (subrem_c != '0)};
                if (subrem_next == '0)
                begin
                    sp_done = 1'b1;
                end
            end
            default:
            begin
                phase_next = ph_c;
            end
        endcase

        if (len_check)
        begin
            if (len_total == '0)
            begin
                raise      = 1'b1;
                raise_code = ERR_ZERO;
            end
            else if (len_total > {16'd0, area_next})
            begin
                raise      = 1'b1;
                raise_code = ERR_OVERRUN;
            end
            else
            begin
                acc_next    = len_total - 32'd1;
                subrem_next = len_total - 32'd1;
                phase_next  = PH_SUBTYPE;
            end
        end
        if (len_pending && area_next == '0)
        begin
            raise      = 1'b1;
            raise_code = ERR_OVERRUN;
        end
        if (sp_done)
        begin
            if (area_next == '0)
            begin
                ar_done = 1'b1;
            end
            else
            begin
                phase_next = PH_SUBLEN;
            end
        end
        if (ar_done)
        begin
            fbc_next = '0;
            if (hashed_c)
            begin
                hashed_next = 1'b0;
                area_next   = '0;
                phase_next  = PH_AREALEN;
            end
            else
            begin
                phase_next = PH_QUICK;
            end
        end
        if (raise)
        begin
            err_next   = raise_code;
            phase_next = PH_ERROR;
        end
    end

    // result fields
    always_comb
    begin
        res          = '0;
        res.byte_out = in_byte_reg;
        res_role     = ROLE_MATERIAL;
        res_last     = 1'b0;
        if (phase_next == PH_ERROR)
        begin
            res_role       = ROLE_ERROR;
            res.error_code = err_next;
        end
        else
        begin
            unique case (ph_c) inside
                PH_MARKER:  res_role = ROLE_MARKER;
                PH_TYPE:    res_role = ROLE_TYPE;
                PH_CREATED: res_role = ROLE_CREATED;
                PH_SIGNER:  res_role = ROLE_SIGNER;
                PH_PKALG:   res_role = ROLE_PKALG;
                PH_HASHALG: res_role = ROLE_HASHALG;
                PH_QUICK:   res_role = ROLE_QUICK;
                PH_AREALEN: res_role = ROLE_AREALEN;
                PH_SUBLEN, PH_SUBLEN_MORE:
                begin
                    res_role           = ROLE_SUBLEN;
                    res.in_hashed_area = hashed_c;
                    if (phase_next == PH_SUBTYPE)
                    begin
                        res.subpacket_data_length = acc_next;
                    end
                end
                PH_SUBTYPE, PH_SUBDATA:
                begin
                    res_role                  = (ph_c == PH_SUBTYPE) ? ROLE_SUBTYPE
                                                                     : ROLE_SUBDATA;
                    res.in_hashed_area        = hashed_c;
                    res.subpkt_type           = type_next;
                    res.critical_flag         = crit_next;
                    res.subpacket_data_length = acc_next;
                    res.header_done           = (ph_c == PH_SUBTYPE);
                    res_last                  = (subrem_next == '0);
                end
                default:    res_role = ROLE_MATERIAL;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            fbc_reg       <= '0;
            ver_reg       <= VER_NONE;
            area_reg      <= '0;
            acc_reg       <= '0;
            subrem_reg    <= '0;
            type_reg      <= '0;
            crit_reg      <= 1'b0;
            hashed_reg    <= 1'b0;
            err_reg       <= ERR_NONE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance && in_valid_reg)
            begin
                phase_reg  <= phase_next;
                fbc_reg    <= fbc_next;
                ver_reg    <= ver_next;
                area_reg   <= area_next;
                acc_reg    <= acc_next;
                subrem_reg <= subrem_next;
                type_reg   <= type_next;
                crit_reg   <= crit_next;
                hashed_reg <= hashed_next;
                err_reg    <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
            in_ver_reg   <= s_tuser[8:1];
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= res;
            out_role_reg <= res_role;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_role_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/pgpsbf_checker.sv =====
// port checker for the signature body framer, bound to the framer core
module pgpsbf_props
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [pgpsbf_pkg::TDATA_IN_W-1:0]  s_tdata,
    input logic [pgpsbf_pkg::TUSER_IN_W-1:0]  s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [pgpsbf_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic [pgpsbf_pkg::TUSER_OUT_W-1:0] m_tuser,
    input logic                               m_tlast
);
    import pgpsbf_pkg::*;

    result_t r;
    assign r = m_tdata;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("stalled result changed");

    // error role carries a nonzero code, other roles carry none
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == ROLE_ERROR) == (r.error_code != ERR_NONE)))
        else $error("error code does not match role");

    // header done only on a subpacket type byte
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.header_done |-> m_tuser == ROLE_SUBTYPE)
        else $error("header done outside a type byte");

    // last of subpacket only on type or data bytes
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == ROLE_SUBTYPE || m_tuser == ROLE_SUBDATA)
        else $error("last of subpacket outside a subpacket");

    // input backpressure only while a result is stalled
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

endmodule

bind pgp_signature_body_framer_core pgpsbf_props u_pgpsbf_props (.*);

// ===== dv/pgpsbf_checker.sv =====
// checker for the signature body framer: predicts each byte's tag and compares results
module pgpsbf_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [pgpsbf_pkg::TDATA_IN_W-1:0]   s_tdata,   // data_byte
    input  logic [pgpsbf_pkg::TUSER_IN_W-1:0]   s_tuser,   // start_of_body, body_version
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // byte_out, in_hashed_area, subpkt_type, critical_flag,
    // subpacket_data_length, header_done, error_code, zero pad
    input  logic [pgpsbf_pkg::TDATA_OUT_W-1:0]  m_tdata,
    input  logic [pgpsbf_pkg::TUSER_OUT_W-1:0]  m_tuser,   // byte_role
    input  logic                                m_tlast,   // last_of_subpacket
    output int                                  mismatches,
    output int                                  outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import pgpsbf_pkg::*;

    typedef struct packed {
        logic [3:0] role;
        logic       last;
        result_t    body;
    } byte_tag_t;

    byte_tag_t expected_tags[$];

    phase_t      parse_phase;
    logic [2:0]  field_cnt;
    logic [1:0]  fmt;
    logic [15:0] area_left;
    logic [31:0] len_acc;
    logic [31:0] data_left;
    logic [6:0]  sp_type;
    logic        sp_crit;
    logic        in_hashed;
    logic [2:0]  err_latched;

    initial mismatches = 0;

    function automatic void clear_parse();
        parse_phase = PH_IDLE;
        field_cnt   = '0;
        fmt         = VER_NONE;
        area_left   = '0;
        len_acc     = '0;
        data_left   = '0;
        sp_type     = '0;
        sp_crit     = 1'b0;
        in_hashed   = 1'b0;
        err_latched = ERR_NONE;
    endfunction

    function automatic void area_done();
        field_cnt = '0;
        if (in_hashed)
        begin
            in_hashed   = 1'b0;
            area_left   = '0;
            parse_phase = PH_AREALEN;
        end
        else
            parse_phase = PH_QUICK;
    endfunction

    function automatic void subpacket_done();
        if (area_left == 0)
            area_done();
        else
            parse_phase = PH_SUBLEN;
    endfunction

    function automatic void eat_area_byte();
        if (area_left != 0)
            area_left = area_left - 16'd1;
    endfunction

    // finish a length encoding; returns the error it raises, if any
    function automatic logic [2:0] close_length(input logic [31:0] total);
        if (total == 0)
            return ERR_ZERO;
        if (total > {16'd0, area_left})
            return ERR_OVERRUN;
        len_acc     = total - 32'd1;
        data_left   = len_acc;
        parse_phase = PH_SUBTYPE;
        return ERR_NONE;
    endfunction

    function automatic byte_tag_t tag_byte(input logic [7:0] b, input logic st,
                                           input logic [7:0] ver);
        byte_tag_t  t;
        logic [2:0] fault;
        t = '0;
        t.role = ROLE_MATERIAL;
        t.body.byte_out = b;
        fault = ERR_NONE;
        if (st)
        begin
            clear_parse();
            if (ver == VERSION_2 || ver == VERSION_3)
            begin
                fmt = VER_OLD;
                parse_phase = PH_MARKER;
            end
            else if (ver == VERSION_4)
            begin
                fmt = VER_NEW;
                parse_phase = PH_TYPE;
            end
            else
            begin
                err_latched = ERR_VERSION;
                parse_phase = PH_ERROR;
            end
        end
        case (parse_phase)
            PH_ERROR:
                fault = err_latched;
            PH_MARKER:
            begin
                t.role = ROLE_MARKER;
                if (b != MARKER_BYTE)
                    fault = ERR_MARKER;
                else
                    parse_phase = PH_TYPE;
            end
            PH_TYPE:
            begin
                t.role = ROLE_TYPE;
                field_cnt = '0;
                parse_phase = (fmt == VER_OLD) ? PH_CREATED : PH_PKALG;
            end
            PH_CREATED:
            begin
                t.role = ROLE_CREATED;
                if (field_cnt >= CNT_CREATED_LAST)
                begin
                    field_cnt = '0;
                    parse_phase = PH_SIGNER;
                end
                else
                    field_cnt = field_cnt + 3'd1;
            end
            PH_SIGNER:
            begin
                t.role = ROLE_SIGNER;
                if (field_cnt >= CNT_SIGNER_LAST)
                begin
                    field_cnt = '0;
                    parse_phase = PH_PKALG;
                end
                else
                    field_cnt = field_cnt + 3'd1;
            end
            PH_PKALG:
            begin
                t.role = ROLE_PKALG;
                parse_phase = PH_HASHALG;
            end
            PH_HASHALG:
            begin
                t.role = ROLE_HASHALG;
                field_cnt = '0;
                if (fmt == VER_OLD)
                    parse_phase = PH_QUICK;
                else
                begin
                    in_hashed = 1'b1;
                    area_left = '0;
                    parse_phase = PH_AREALEN;
                end
            end
            PH_QUICK:
            begin
                t.role = ROLE_QUICK;
                if (field_cnt >= 3'd1)
                begin
                    field_cnt = '0;
                    parse_phase = PH_MATERIAL;
                end
                else
                    field_cnt = field_cnt + 3'd1;
            end
            PH_AREALEN:
            begin
                t.role = ROLE_AREALEN;
                area_left = {area_left[7:0], b};
                if (field_cnt >= 3'd1)
                begin
                    field_cnt = '0;
                    if (area_left == 0)
                        area_done();
                    else
                        parse_phase = PH_SUBLEN;
                end
                else
                    field_cnt = 3'd1;
            end
            PH_SUBLEN:
            begin
                t.role = ROLE_SUBLEN;
                t.body.in_hashed_area = in_hashed;
                eat_area_byte();
                if (b <= ONE_OCTET_MAX)
                    fault = close_length({24'd0, b});
                else
                begin
                    if (b <= TWO_OCTET_MAX)
                    begin
                        len_acc = {24'd0, b - TWO_OCTET_BASE};
                        field_cnt = CNT_TWO_PENDING;
                    end
                    else
                    begin
                        len_acc = '0;
                        field_cnt = CNT_FIVE_OCTET;
                    end
                    parse_phase = PH_SUBLEN_MORE;
                    if (area_left == 0)
                        fault = ERR_OVERRUN;
                end
                if (parse_phase == PH_SUBTYPE)
                    t.body.subpacket_data_length = len_acc;
            end
            PH_SUBLEN_MORE:
            begin
                t.role = ROLE_SUBLEN;
                t.body.in_hashed_area = in_hashed;
                eat_area_byte();
                if (field_cnt == CNT_TWO_PENDING)
                begin
                    field_cnt = '0;
                    fault = close_length((len_acc << 8) + {24'd0, b} + TWO_OCTET_OFFSET);
                end
                else
                begin
                    len_acc = {len_acc[23:0], b};
                    if (field_cnt != 0)
                        field_cnt = field_cnt - 3'd1;
                    if (field_cnt == 0)
                        fault = close_length(len_acc);
                    else if (area_left == 0)
                        fault = ERR_OVERRUN;
                end
                if (parse_phase == PH_SUBTYPE)
                    t.body.subpacket_data_length = len_acc;
            end
            PH_SUBTYPE:
            begin
                eat_area_byte();
                sp_crit = b[7];
                sp_type = b[6:0];
                t.role = ROLE_SUBTYPE;
                t.body.header_done = 1'b1;
                t.body.in_hashed_area = in_hashed;
                t.body.subpkt_type = sp_type;
                t.body.critical_flag = sp_crit;
                t.body.subpacket_data_length = len_acc;
                if (data_left == 0)
                begin
                    t.last = 1'b1;
                    subpacket_done();
                end
                else
                    parse_phase = PH_SUBDATA;
            end
            PH_SUBDATA:
            begin
                eat_area_byte();
                if (data_left != 0)
                    data_left = data_left - 32'd1;
                t.role = ROLE_SUBDATA;
                t.body.in_hashed_area = in_hashed;
                t.body.subpkt_type = sp_type;
                t.body.critical_flag = sp_crit;
                t.body.subpacket_data_length = len_acc;
                if (data_left == 0)
                begin
                    t.last = 1'b1;
                    subpacket_done();
                end
            end
            default:
                t.role = ROLE_MATERIAL;
        endcase
        if (fault != ERR_NONE)
        begin
            err_latched = fault;
            parse_phase = PH_ERROR;
            t = '0;
            t.role = ROLE_ERROR;
            t.body.byte_out = b;
            t.body.error_code = fault;
        end
        return t;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        byte_tag_t want;
        result_t   got;
        if (!rst_n)
        begin
            expected_tags.delete();
            clear_parse();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (expected_tags.size() == 0)
                begin
                    $error("unexpected result: byte 'h%0h role %0d", got.byte_out, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_tags.pop_front();
                    check_field("byte_role", 32'(want.role), 32'(m_tuser));
                    check_field("last_of_subpacket", 32'(want.last), 32'(m_tlast));
                    check_field("byte_out", 32'(want.body.byte_out), 32'(got.byte_out));
                    check_field("in_hashed_area", 32'(want.body.in_hashed_area),
                                32'(got.in_hashed_area));
                    check_field("subpkt_type", 32'(want.body.subpkt_type),
                                32'(got.subpkt_type));
                    check_field("critical_flag", 32'(want.body.critical_flag),
                                32'(got.critical_flag));
                    check_field("subpacket_data_length", want.body.subpacket_data_length,
                                got.subpacket_data_length);
                    check_field("header_done", 32'(want.body.header_done),
                                32'(got.header_done));
                    check_field("error_code", 32'(want.body.error_code),
                                32'(got.error_code));
                    check_field("pad", 32'(want.body.pad), 32'(got.pad));
                end
            end
            if (s_tvalid && s_tready)
                expected_tags.insert(expected_tags.size(),
                                     tag_byte(s_tdata, s_tuser[0], s_tuser[8:1]));
            outstanding <= expected_tags.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the signature body framer: stimulus, handshake pacing and verdict
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pgpsbf_pkg::*;

    localparam logic [7:0] FIVE_OCTET_LEAD = 8'hff;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic [TUSER_IN_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [TUSER_OUT_W-1:0] m_tuser;
    logic                   m_tlast;
    logic                   calm;
    int                     mismatches;
    int                     outstanding;
    int                     sent;

    always #5 clk = ~clk;

    pgp_signature_body_framer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    pgpsbf_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= 27);

    task automatic send_byte(input logic [7:0] b, input logic st, input logic [7:0] ver);
        while (!calm && $urandom_range(99) < 27)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {ver, st};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic put(input logic [7:0] b);
        send_byte(b, 1'b0, 8'($urandom_range(255)));
    endtask

    task automatic open_body(input logic [7:0] ver, input logic [7:0] b);
        send_byte(b, 1'b1, ver);
    endtask

    // hold the sender until every transfer has produced its result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic send_area();
        logic [7:0]  area_bytes[$];
        int unsigned pick;
        int unsigned total;
        logic [15:0] alen;
        repeat ($urandom_range(3))
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                area_bytes.insert(area_bytes.size(), 8'h00);
            else if (pick < 8)
            begin
                area_bytes.insert(area_bytes.size(), FIVE_OCTET_LEAD);
                repeat (4)
                    area_bytes.insert(area_bytes.size(), 8'($urandom_range(255)));
            end
            else if (pick < 12)
            begin
                area_bytes.insert(area_bytes.size(),
                                  8'($urandom_range(TWO_OCTET_BASE, TWO_OCTET_MAX)));
                area_bytes.insert(area_bytes.size(), 8'($urandom_range(255)));
            end
            else
            begin
                total = ((pick < 16) ? $urandom_range(191, 260) : $urandom_range(8)) + 1;
                if (total >= TWO_OCTET_OFFSET)
                begin
                    area_bytes.insert(area_bytes.size(),
                        8'(TWO_OCTET_BASE + ((total - TWO_OCTET_OFFSET) >> 8)));
                    area_bytes.insert(area_bytes.size(), 8'(total - TWO_OCTET_OFFSET));
                end
                else if ($urandom_range(9) == 0)
                begin
                    area_bytes.insert(area_bytes.size(), FIVE_OCTET_LEAD);
                    repeat (3)
                        area_bytes.insert(area_bytes.size(), 8'h00);
                    area_bytes.insert(area_bytes.size(), 8'(total));
                end
                else
                    area_bytes.insert(area_bytes.size(), 8'(total));
                // type octet then data
                repeat (total)
                    area_bytes.insert(area_bytes.size(), 8'($urandom_range(255)));
            end
        end
        pick = $urandom_range(99);
        if (pick < 10)
            alen = 16'($urandom_range(area_bytes.size()));
        else if (pick < 12)
            alen = 16'($urandom_range(16'hffff));
        else
            alen = 16'(area_bytes.size());
        put(alen[15:8]);
        put(alen[7:0]);
        foreach (area_bytes[i])
            put(area_bytes[i]);
    endtask

    task automatic send_new_body();
        open_body(VERSION_4, 8'($urandom_range(255)));
        put(8'($urandom_range(255)));
        put(8'($urandom_range(255)));
        send_area();
        send_area();
        put(8'($urandom_range(255)));
        put(8'($urandom_range(255)));
        repeat ($urandom_range(3))
            put(8'($urandom_range(255)));
    endtask

    task automatic send_old_body();
        logic [7:0] marker;
        marker = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : MARKER_BYTE;
        open_body($urandom_range(1) ? VERSION_3 : VERSION_2, marker);
        repeat (16)
            put(8'($urandom_range(255)));
        repeat ($urandom_range(3))
            put(8'($urandom_range(255)));
    endtask

    initial
    begin : stimulus
        int unsigned pick;
        logic [7:0]  ver;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        calm     = 1'b0;
        sent     = 0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        put(8'hff);                     // before any start
        open_body(8'hff, 8'h00);        // unknown version
        put(8'h00);
        open_body(VERSION_3, 8'h04);    // bad marker
        open_body(VERSION_4, 8'h00);
        put(8'h01);
        put(8'h02);
        put(8'h00);
        put(8'h09);
        put(8'h01);                     // empty critical subpacket
        put(8'h80);
        put(FIVE_OCTET_LEAD);
        put(8'h00);
        put(8'h00);
        put(8'h00);
        put(8'h02);
        put(8'h7f);
        put(8'hff);
        put(8'h00);                     // empty unhashed area
        put(8'h00);
        put(8'haa);
        put(8'h55);
        put(8'h3c);
        open_body(VERSION_4, 8'h00);    // zero subpacket length
        put(8'h11);
        put(8'h08);
        put(8'h00);
        put(8'h01);
        put(8'h00);
        drain();

        while (sent < 1530)
        begin
            calm <= (sent >= 700 && sent < 1000);
            pick = $urandom_range(99);
            if (pick < 20)
                send_old_body();
            else if (pick < 80)
                send_new_body();
            else if (pick < 90)
            begin
                do
                    ver = 8'($urandom_range(255));
                while (ver inside {VERSION_2, VERSION_3, VERSION_4});
                open_body(ver, 8'($urandom_range(255)));
                repeat ($urandom_range(3))
                    put(8'($urandom_range(255)));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
                              8'($urandom_range(255)));
            end
            if ($urandom_range(19) == 0)
                drain();
        end

        drain();
        repeat (10)
            @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
